// ===== rtl/core/asit_pkg.sv =====
// ----------------------------------------------------------------------------
// Speed integrator and run timer package
// Item types, register indexes, action codes and derived constants.
// ----------------------------------------------------------------------------
package asit_pkg;

   localparam int TICK_COUNT_BITS = 20;
   localparam longint TICK_MAX = (64'd1 << TICK_COUNT_BITS) - 64'd1;
   localparam int TICK_SECS_BITS = $clog2(TICK_MAX / 1000 + 1);

   localparam int READING_BITS = 12;
   localparam int ACCEL_BITS = 10;
   localparam int SPEED_BITS = 15;
   localparam int TARGET_BITS = 8;

   localparam int AREA_BITS = 30;
   localparam longint AREA_MAX = (64'd1 << AREA_BITS) - 64'd1;
   localparam longint SPEED_DIVISOR = 93359;
   localparam int REM_BITS = $clog2(SPEED_DIVISOR + 2 * (1 << READING_BITS));
   localparam longint SPEED_SAT_QUOT = (2 * AREA_MAX) / SPEED_DIVISOR;
   localparam longint SPEED_SAT_REM = (2 * AREA_MAX) % SPEED_DIVISOR;

   localparam longint RUN_TIME_MAX = 131071;
   localparam longint RUN_SECS_MAX = RUN_TIME_MAX / 100;
   localparam longint RUN_HUND_MAX = RUN_TIME_MAX % 100;
   localparam int SECS_BITS = 11;
   localparam int HUND_BITS = 7;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 10;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_SPEED = 2'd1;
   localparam logic [ACCEL_BITS-1:0] START_THRESHOLD_RESET = 10'd500;
   localparam logic [TARGET_BITS-1:0] TARGET_SPEED_RESET = 8'd60;

   localparam logic [1:0] ACTION_SAMPLE = 2'd0;
   localparam logic [1:0] ACTION_TICK = 2'd1;
   localparam logic [1:0] ACTION_SOFT_RESET = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] accel_high;
      logic [7:0] accel_low;
   } req_type;

   typedef struct packed {
      logic [SPEED_BITS-1:0] cur_speed;
      logic [SPEED_BITS-1:0] peak_speed;
      logic [ACCEL_BITS-1:0] cur_accel;
      logic [ACCEL_BITS-1:0] peak_accel;
      logic [SECS_BITS-1:0] run_seconds;
      logic [HUND_BITS-1:0] run_hundredths;
      logic [SECS_BITS-1:0] best_seconds;
      logic [HUND_BITS-1:0] best_hundredths;
      logic run_finished;
   } rsp_type;

endpackage

// ===== rtl/core/accel_speed_integrator_timer.sv =====
// ----------------------------------------------------------------------------
// Accelerometer speed integrator and run timer
// Tracks acceleration, integrated speed and run time from samples and ticks.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle unless a stalled output holds the input
// register full. An input register holds the item, the state is updated in
// one pass and the result register presents the snapshot. The speed is kept
// as a running quotient and remainder of twice the area sum by the divisor,
// and the tick count is kept alongside as milliseconds, hundredths and
// seconds, so that no divider lies in the path. The input register takes an
// item while a result waits on a stalled output only if it is empty.
module accel_speed_integrator_timer (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  asit_pkg::req_type req_item,
   output logic rsp_valid,
   input  logic rsp_stall,
   output asit_pkg::rsp_type rsp_item,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [asit_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [asit_pkg::CSR_DATA_BITS-1:0] csr_data
);

   localparam int TB = asit_pkg::TICK_COUNT_BITS;
   localparam int TSB = asit_pkg::TICK_SECS_BITS;
   localparam int AB = asit_pkg::ACCEL_BITS;
   localparam int SB = asit_pkg::SPEED_BITS;
   localparam int RB = asit_pkg::REM_BITS;
   localparam int ARB = asit_pkg::AREA_BITS;
   localparam int RDB = asit_pkg::READING_BITS;
   localparam int SCB = asit_pkg::SECS_BITS;
   localparam int HB = asit_pkg::HUND_BITS;

   logic in_valid_ff, in_valid_in;
   asit_pkg::req_type in_item_ff;
   logic out_valid_ff, out_valid_in;
   asit_pkg::rsp_type out_item_ff, out_item_in;
   logic advance, accept;

   logic [AB-1:0] threshold_ff;
   logic [asit_pkg::TARGET_BITS-1:0] target_ff;

   logic [TB-1:0] tick_count_ff, tick_count_in;
   logic [3:0] tick_unit_ff, tick_unit_in;
   logic [HB-1:0] tick_hund_ff, tick_hund_in;
   logic [TSB-1:0] tick_secs_ff, tick_secs_in;
   logic [ARB-1:0] area_ff, area_in;
   logic [SB-1:0] area_quot_ff, area_quot_in;
   logic [RB-1:0] area_rem_ff, area_rem_in;
   logic [RDB-1:0] reading_ff, reading_in;
   logic [AB-1:0] accel_now_ff, accel_now_in;
   logic [AB-1:0] accel_peak_ff, accel_peak_in;
   logic [SB-1:0] speed_now_ff, speed_now_in;
   logic [SB-1:0] speed_peak_ff, speed_peak_in;
   logic [SCB-1:0] run_secs_ff, run_secs_in;
   logic [HB-1:0] run_hund_ff, run_hund_in;
   logic [SCB-1:0] best_secs_ff, best_secs_in;
   logic [HB-1:0] best_hund_ff, best_hund_in;
   logic finished_ff, finished_in;

   logic [ARB:0] area_sum;
   logic [RB-1:0] rem_sum;
   logic run_clamp;

   assign advance = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign accept = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_item = out_item_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (in_valid_ff && advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      tick_count_in = tick_count_ff;
      tick_unit_in = tick_unit_ff;
      tick_hund_in = tick_hund_ff;
      tick_secs_in = tick_secs_ff;
      area_in = area_ff;
      area_quot_in = area_quot_ff;
      area_rem_in = area_rem_ff;
      reading_in = reading_ff;
      accel_now_in = accel_now_ff;
      accel_peak_in = accel_peak_ff;
      speed_now_in = speed_now_ff;
      speed_peak_in = speed_peak_ff;
      run_secs_in = run_secs_ff;
      run_hund_in = run_hund_ff;
      best_secs_in = best_secs_ff;
      best_hund_in = best_hund_ff;
      finished_in = finished_ff;

      area_sum = {1'b0, area_ff} + (ARB + 1)'(reading_ff);
      rem_sum = area_rem_ff + RB'({reading_ff, 1'b0});
      run_clamp = (32'(tick_secs_ff) > 32'(asit_pkg::RUN_SECS_MAX))
         || ((32'(tick_secs_ff) == 32'(asit_pkg::RUN_SECS_MAX))
         && (32'(tick_hund_ff) > 32'(asit_pkg::RUN_HUND_MAX)));

      case (in_item_ff.action)
         asit_pkg::ACTION_SAMPLE: begin
            reading_in = {in_item_ff.accel_high, in_item_ff.accel_low[7:4]};
            accel_now_in = reading_in[RDB-1:2];
            if (accel_now_in > accel_peak_ff) begin
               accel_peak_in = accel_now_in;
            end
            if (finished_ff) begin
               run_secs_in = best_secs_ff;
               run_hund_in = best_hund_ff;
            end else if (accel_peak_in < threshold_ff) begin
               tick_count_in = '0;
               tick_unit_in = '0;
               tick_hund_in = '0;
               tick_secs_in = '0;
            end else if (run_clamp) begin
               run_secs_in = SCB'(asit_pkg::RUN_SECS_MAX);
               run_hund_in = HB'(asit_pkg::RUN_HUND_MAX);
            end else begin
               run_secs_in = SCB'(tick_secs_ff);
               run_hund_in = tick_hund_ff;
            end
            if (speed_now_ff >= SB'(target_ff)) begin
               finished_in = 1'b1;
            end
            if ({run_secs_in, run_hund_in} > {best_secs_ff, best_hund_ff}) begin
               best_secs_in = run_secs_in;
               best_hund_in = run_hund_in;
            end
         end
         asit_pkg::ACTION_TICK: begin
            if (64'(tick_count_ff) != 64'(asit_pkg::TICK_MAX)) begin
               tick_count_in = tick_count_ff + 1'b1;
               if (tick_unit_ff == 4'd9) begin
                  tick_unit_in = '0;
                  if (tick_hund_ff == HB'(99)) begin
                     tick_hund_in = '0;
                     tick_secs_in = tick_secs_ff + 1'b1;
                  end else begin
                     tick_hund_in = tick_hund_ff + 1'b1;
                  end
               end else begin
                  tick_unit_in = tick_unit_ff + 1'b1;
               end
            end
            if (accel_peak_ff < threshold_ff) begin
               area_in = '0;
               area_quot_in = '0;
               area_rem_in = '0;
            end else if (64'(area_sum) > 64'(asit_pkg::AREA_MAX)) begin
               area_in = ARB'(asit_pkg::AREA_MAX);
               area_quot_in = SB'(asit_pkg::SPEED_SAT_QUOT);
               area_rem_in = RB'(asit_pkg::SPEED_SAT_REM);
            end else begin
               area_in = area_sum[ARB-1:0];
               if (64'(rem_sum) >= 64'(asit_pkg::SPEED_DIVISOR)) begin
                  area_rem_in = rem_sum - RB'(asit_pkg::SPEED_DIVISOR);
                  area_quot_in = area_quot_ff + 1'b1;
               end else begin
                  area_rem_in = rem_sum;
               end
            end
            speed_now_in = area_quot_in;
            if (speed_now_in > speed_peak_ff) begin
               speed_peak_in = speed_now_in;
            end
         end
         asit_pkg::ACTION_SOFT_RESET: begin
            finished_in = 1'b0;
            run_secs_in = '0;
            run_hund_in = '0;
            speed_now_in = '0;
            speed_peak_in = '0;
            accel_now_in = '0;
            accel_peak_in = '0;
         end
         default: begin
         end
      endcase

      out_item_in.cur_speed = speed_now_in;
      out_item_in.peak_speed = speed_peak_in;
      out_item_in.cur_accel = accel_now_in;
      out_item_in.peak_accel = accel_peak_in;
      out_item_in.run_seconds = run_secs_in;
      out_item_in.run_hundredths = run_hund_in;
      out_item_in.best_seconds = best_secs_in;
      out_item_in.best_hundredths = best_hund_in;
      out_item_in.run_finished = finished_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (in_valid_ff && advance) begin
         out_item_ff <= out_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         threshold_ff <= asit_pkg::START_THRESHOLD_RESET;
         target_ff <= asit_pkg::TARGET_SPEED_RESET;
         tick_count_ff <= '0;
         tick_unit_ff <= '0;
         tick_hund_ff <= '0;
         tick_secs_ff <= '0;
         area_ff <= '0;
         area_quot_ff <= '0;
         area_rem_ff <= '0;
         reading_ff <= '0;
         accel_now_ff <= '0;
         accel_peak_ff <= '0;
         speed_now_ff <= '0;
         speed_peak_ff <= '0;
         run_secs_ff <= '0;
         run_hund_ff <= '0;
         best_secs_ff <= '0;
         best_hund_ff <= '0;
         finished_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               asit_pkg::CSR_START_THRESHOLD: begin
                  threshold_ff <= csr_data[AB-1:0];
               end
               asit_pkg::CSR_TARGET_SPEED: begin
                  target_ff <= csr_data[asit_pkg::TARGET_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         if (in_valid_ff && advance) begin
            tick_count_ff <= tick_count_in;
            tick_unit_ff <= tick_unit_in;
            tick_hund_ff <= tick_hund_in;
            tick_secs_ff <= tick_secs_in;
            area_ff <= area_in;
            area_quot_ff <= area_quot_in;
            area_rem_ff <= area_rem_in;
            reading_ff <= reading_in;
            accel_now_ff <= accel_now_in;
            accel_peak_ff <= accel_peak_in;
            speed_now_ff <= speed_now_in;
            speed_peak_ff <= speed_peak_in;
            run_secs_ff <= run_secs_in;
            run_hund_ff <= run_hund_in;
            best_secs_ff <= best_secs_in;
            best_hund_ff <= best_hund_in;
            finished_ff <= finished_in;
         end
      end
   end

endmodule
